// ===== design/assert_macros.svh =====
// assertion helpers for the edge list parser rtl
// no dependencies; pulled in by the modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg)
`endif
`endif

// ===== design/elp_pkg.sv =====
// shared types and constants for the edge list text parser
// no dependencies; imported by edge_list_text_parser_unit
package elp_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned NodeW   = 32;
  localparam int unsigned CountW  = 10;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 80;

  localparam logic [CountW-1:0] EdgeLimitReset = CountW'(50);

  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChComma = 8'h2C;
  localparam logic [CharW-1:0] ChBar   = 8'h7C;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;

  typedef enum logic [1:0] {
    CLS_SEP   = 2'd0,
    CLS_LINK  = 2'd1,
    CLS_DIGIT = 2'd2
  } char_class_t;

  typedef struct packed {
    logic [CountW-1:0] edges_so_far;
    logic              list_full;
    logic              syntax_error;
    logic [NodeW-1:0]  edge_target;
    logic [NodeW-1:0]  edge_source;
    logic              edge_valid;
  } parse_result_t;

endpackage

// ===== design/edge_list_text_parser_unit.sv =====
// edge list text parser: one character per request, one result per request
// depends on elp_pkg and assert_macros.svh
//
//  channel  | dir | fields (lsb first)
//  s_*      | in  | tdata: char_code[7:0], line_start[8], zero pad
//  m_*      | out | tdata: edge_valid, edge_source, edge_target, syntax_error,
//           |     |        list_full, edges_so_far, zero pad
//  cfg_*    | in  | edge_limit write, 10 bits
//
// one request per cycle sustained while m is not stalled; m_tvalid rises after the
// s accept once the character has gone through the input register, then the parse
// step into the result register
// the parse step is a multiply by ten as two shifts and adds plus class compares
// rst is synchronous; it clears the parser state and both valid flags and sets edge_limit to 50
// a stall on m holds the result register, then the input register, then s_tready
`include "assert_macros.svh"

module edge_list_text_parser_unit #(
  parameter logic [elp_pkg::CountW-1:0] EDGE_LIMIT_RESET = elp_pkg::EdgeLimitReset
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [elp_pkg::InDataW-1:0]  s_tdata,   // char_code[7:0], line_start[8]
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [elp_pkg::OutDataW-1:0] m_tdata,   // edge_valid, edge_source[32],
                                                  // edge_target[32], syntax_error,
                                                  // list_full, edges_so_far[10]
  input  logic                         cfg_we,
  input  logic [elp_pkg::CountW-1:0]   cfg_wdata
);
  import elp_pkg::*;

  logic [CountW-1:0] edge_limit;

  // input register
  logic             in_full;
  logic [CharW-1:0] in_char;
  logic             in_line_start;

  // parser state
  logic [NodeW-1:0]  number_value,   number_value_next;
  logic              value_present,  value_present_next;
  char_class_t       last_class,     last_class_next;
  char_class_t       earlier_class,  earlier_class_next;
  logic [CountW-1:0] edge_count,     edge_count_next;
  logic [NodeW-1:0]  pending_source, pending_source_next;

  // result register
  logic          out_valid;
  parse_result_t out_res;
  parse_result_t res_next;

  logic advance;

  assign advance  = in_full && (!out_valid || m_tready);
  assign s_tready = !in_full || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OutDataW - $bits(parse_result_t)){1'b0}}, out_res};

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_limit <= EDGE_LIMIT_RESET;
    end else if (cfg_we) begin
      edge_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tready) begin
      in_full <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char       <= s_tdata[CharW-1:0];
      in_line_start <= s_tdata[CharW];
    end
  end

  always_comb begin
    logic [NodeW-1:0]  num_cur;
    logic              vp_cur;
    char_class_t       last_cur;
    char_class_t       earlier_cur;
    logic [CountW-1:0] count_cur;
    logic [NodeW-1:0]  pend_cur;
    logic              is_sep;
    logic              is_digit;

    // line start wipes the state before this character is looked at
    num_cur     = in_line_start ? '0 : number_value;
    vp_cur      = in_line_start ? 1'b0 : value_present;
    last_cur    = in_line_start ? CLS_SEP : last_class;
    earlier_cur = in_line_start ? CLS_SEP : earlier_class;
    count_cur   = in_line_start ? '0 : edge_count;
    pend_cur    = in_line_start ? '0 : pending_source;

    is_sep   = (in_char == ChSpace) || (in_char == ChComma) || (in_char == ChBar);
    is_digit = (in_char >= ChZero) && (in_char <= ChNine);

    number_value_next   = num_cur;
    value_present_next  = vp_cur;
    last_class_next     = last_cur;
    earlier_class_next  = earlier_cur;
    edge_count_next     = count_cur;
    pending_source_next = pend_cur;

    res_next = '0;

    if (count_cur >= edge_limit) begin
      res_next.list_full = 1'b1;
    end else if (is_sep) begin
      // a separator closes an edge only after link then digits
      if (vp_cur && earlier_cur == CLS_LINK && last_cur == CLS_DIGIT) begin
        res_next.edge_valid  = 1'b1;
        res_next.edge_source = pend_cur;
        res_next.edge_target = num_cur;
        edge_count_next      = count_cur + CountW'(1);
        pending_source_next  = '0;
        earlier_class_next   = last_cur;
        number_value_next    = '0;
        value_present_next   = 1'b0;
        last_class_next      = CLS_SEP;
      end
    end else if (is_digit) begin
      number_value_next  = (num_cur << 3) + (num_cur << 1)
                         + NodeW'(in_char - ChZero);
      value_present_next = 1'b1;
      if (last_cur != CLS_DIGIT) begin
        earlier_class_next = last_cur;
      end
      last_class_next = CLS_DIGIT;
    end else if (last_cur != CLS_LINK) begin
      if (vp_cur) begin
        if (earlier_cur == CLS_SEP && last_cur == CLS_DIGIT) begin
          pending_source_next = num_cur;
          earlier_class_next  = last_cur;
        end else if ((earlier_cur == CLS_DIGIT && last_cur == CLS_SEP) ||
                     (earlier_cur == CLS_LINK && last_cur == CLS_DIGIT)) begin
          // edge closes and its target becomes the next source
          res_next.edge_valid  = 1'b1;
          res_next.edge_source = pend_cur;
          res_next.edge_target = num_cur;
          edge_count_next      = count_cur + CountW'(1);
          pending_source_next  = num_cur;
          earlier_class_next   = last_cur;
        end else begin
          res_next.syntax_error = 1'b1;
        end
      end
      number_value_next  = '0;
      value_present_next = 1'b0;
      last_class_next    = CLS_LINK;
    end

    res_next.edges_so_far = edge_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      number_value   <= '0;
      value_present  <= 1'b0;
      last_class     <= CLS_SEP;
      earlier_class  <= CLS_SEP;
      edge_count     <= '0;
      pending_source <= '0;
    end else if (advance) begin
      number_value   <= number_value_next;
      value_present  <= value_present_next;
      last_class     <= last_class_next;
      earlier_class  <= earlier_class_next;
      edge_count     <= edge_count_next;
      pending_source <= pending_source_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_next;
    end
  end

  `ASSERT_IMPL(a_edge_excl, clk, rst,
    !(out_valid && out_res.edge_valid) || (!out_res.list_full && !out_res.syntax_error),
    "edge result also flagged as full or error")
  `ASSERT_IMPL(a_no_edge_zero, clk, rst,
    !(out_valid && !out_res.edge_valid) || (out_res.edge_source == '0 && out_res.edge_target == '0),
    "nodes nonzero on a result without an edge")
  `ASSERT_NEXT(a_advance_loads, clk, rst, advance, out_valid,
    "result register not loaded after a parse step")
  `ASSERT_IMPL(a_empty_ready, clk, rst, in_full || s_tready,
    "input register empty but not ready")

endmodule
